[rtl/ffsa_pkg.sv]
// Package for the first-fit segment allocator.
// Default sizes and result status codes; no dependencies.
package ffsa_pkg;
	localparam int ADDR_BITS_DEF    = 20;
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ALIGN_BYTES_DEF  = 16;

	localparam int SIZE_W = 20;
	localparam int HEAP_W = 21;
	localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(65536);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADADDR = 2'd2
	} status_t;
endpackage

[rtl/first_fit_segment_allocator_top.sv]
// First-fit segment allocator with coalescing: top level.
// Segment table in one synchronous memory, walked by a control FSM; uses ffsa_pkg.
//
// One request (allocate or free) is in work at a time; each yields one result
// transaction. A walk step is one memory read per cycle. An allocate walks the
// list to the first free entry that fits and writes a second entry when it splits.
// A free walks the list to find its entry, then a merge pass walks the whole list.
// While m_tready low holds back the previous result, the FSM waits in DONE until
// that result is taken. After reset and after each heap_bytes write, the INIT state
// rebuilds the list before a request is taken.
module first_fit_segment_allocator_top
	import ffsa_pkg::*;
#(
	parameter int ADDR_BITS    = ADDR_BITS_DEF,
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // alloc_size[19:0], free_address[39:20]
	input  logic [0:0]        s_tuser,   // mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // address[19:0], status[21:20], zero pad
	input  logic              cfg_we,
	input  logic [HEAP_W-1:0] cfg_wdata  // heap_bytes
);
	localparam int IB = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int LW = IB + 1;
	localparam int W  = ((ADDR_BITS > HEAP_W) ? ADDR_BITS : HEAP_W) + 2;
	localparam logic [LW-1:0] NONE = LW'(MAX_SEGMENTS);
	localparam logic [W-1:0] HDR  = W'(HEADER_BYTES);
	localparam logic [W-1:0] ALN  = W'(ALIGN_BYTES);
	localparam logic [W-1:0] CAP  = W'(1) << ADDR_BITS;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS:0]   len;
		logic                 free;
		logic [LW-1:0]        link;
	} entry_t;

	typedef enum logic [3:0] {
		INIT, IDLE, A_CHK, A_WR2, F_CHK, M_START, M_CUR, M_NXT, DONE
	} state_t;

	state_t                  state_q;
	entry_t                  mem [MAX_SEGMENTS];
	entry_t                  rdata_q, ent_q, wd;
	logic                    re, we;
	logic [IB-1:0]           ra, wa;
	logic [MAX_SEGMENTS-1:0] spare_q;
	logic [LW-1:0]           head_q;
	logic [W-1:0]            heap_q, need_q;
	logic [IB-1:0]           cur_q, nxt_q;
	logic [SIZE_W-1:0]       faddr_q, res_addr_q;
	status_t                 res_st_q, out_st_q;
	logic [SIZE_W-1:0]       out_addr_q;
	logic                    out_v_q;

	logic [W-1:0]  size_w, need_d, rlen, rstart, lstart, heap_cap;
	logic          fit, split, match, mergeable, sp_any;
	logic [IB-1:0] sp_idx;
	entry_t        merged;

	function automatic logic [IB:0] first_spare(input logic [MAX_SEGMENTS-1:0] v);
		logic [IB:0] r;
		r = {1'b1, IB'(0)};
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--)
			if (v[i]) r = {1'b0, IB'(i)};
		return r;
	endfunction

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_st_q, out_addr_q};

	always_comb begin
		logic [IB:0] fs;
		fs       = first_spare(spare_q);
		sp_any   = !fs[IB];
		sp_idx   = fs[IB-1:0];
		size_w   = W'(s_tdata[SIZE_W-1:0]);
		need_d   = W'(((size_w + ALN - W'(1)) / ALIGN_BYTES) * ALIGN_BYTES);
		rlen     = W'(rdata_q.len);
		rstart   = W'(rdata_q.start);
		lstart   = W'(ent_q.start);
		heap_cap = (heap_q > CAP) ? CAP : heap_q;
		fit      = rdata_q.free && (rlen >= need_q);
		split    = (rlen >= need_q + HDR + ALN) && sp_any;
		match    = (rstart + HDR) == W'(faddr_q);
		mergeable = ent_q.free && rdata_q.free && (lstart + HDR + W'(ent_q.len) == rstart);
		merged      = ent_q;
		merged.len  = (ADDR_BITS+1)'(W'(ent_q.len) + HDR + rlen);
		merged.link = rdata_q.link;
	end

	always_comb begin
		re = 1'b0;
		ra = head_q[IB-1:0];
		we = 1'b0;
		wa = cur_q;
		wd = rdata_q;
		unique case (state_q)
			INIT: begin
				we       = 1'b1;
				wa       = '0;
				wd.start = '0;
				wd.len   = (ADDR_BITS+1)'(heap_cap - HDR);
				wd.free  = 1'b1;
				wd.link  = NONE;
			end
			IDLE: re = s_tvalid;
			A_CHK: begin
				if (fit) begin
					we = 1'b1;
					if (split) begin
						wa       = sp_idx;
						wd.start = ADDR_BITS'(rstart + HDR + need_q);
						wd.len   = (ADDR_BITS+1)'(rlen - need_q - HDR);
						wd.free  = 1'b1;
					end else begin
						wd.free = 1'b0;
					end
				end else begin
					re = 1'b1;
					ra = rdata_q.link[IB-1:0];
				end
			end
			A_WR2: begin
				we = 1'b1;
				wd = ent_q;
			end
			F_CHK: begin
				if (match) begin
					we      = !rdata_q.free;
					wd.free = 1'b1;
				end else begin
					re = 1'b1;
					ra = rdata_q.link[IB-1:0];
				end
			end
			M_START: re = 1'b1;
			M_CUR: begin
				re = 1'b1;
				ra = rdata_q.link[IB-1:0];
			end
			M_NXT: begin
				re = 1'b1;
				ra = rdata_q.link[IB-1:0];
				we = mergeable;
				wd = merged;
			end
			DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INIT;
			heap_q  <= W'(HEAP_RESET);
			head_q  <= NONE;
			spare_q <= '1;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready && (cfg_we || state_q != DONE)) out_v_q <= 1'b0;
			if (cfg_we) begin
				heap_q  <= W'(cfg_wdata);
				state_q <= INIT;
			end else begin
				unique case (state_q)
					INIT: begin
						spare_q <= '1;
						head_q  <= NONE;
						if (heap_cap >= HDR + ALN) begin
							spare_q[0] <= 1'b0;
							head_q     <= '0;
						end
						state_q <= IDLE;
					end
					IDLE: begin
						if (s_tvalid) begin
							need_q     <= need_d;
							faddr_q    <= s_tdata[39:20];
							cur_q      <= head_q[IB-1:0];
							res_addr_q <= '0;
							if (head_q == NONE) begin
								res_st_q <= s_tuser[0] ? ST_BADADDR : ST_NOFIT;
								state_q  <= DONE;
							end else if (s_tuser[0]) begin
								state_q <= F_CHK;
							end else if (size_w == '0) begin
								res_st_q <= ST_NOFIT;
								state_q  <= DONE;
							end else begin
								state_q <= A_CHK;
							end
						end
					end
					A_CHK: begin
						if (fit) begin
							res_addr_q <= SIZE_W'(rstart + HDR);
							res_st_q   <= ST_OK;
							if (split) begin
								spare_q[sp_idx] <= 1'b0;
								ent_q.start <= rdata_q.start;
								ent_q.len   <= (ADDR_BITS+1)'(need_q);
								ent_q.free  <= 1'b0;
								ent_q.link  <= LW'(sp_idx);
								state_q     <= A_WR2;
							end else begin
								state_q <= DONE;
							end
						end else if (rdata_q.link == NONE) begin
							res_st_q <= ST_NOFIT;
							state_q  <= DONE;
						end else begin
							cur_q <= rdata_q.link[IB-1:0];
						end
					end
					A_WR2: state_q <= DONE;
					F_CHK: begin
						if (match) begin
							res_st_q <= rdata_q.free ? ST_BADADDR : ST_OK;
							state_q  <= rdata_q.free ? DONE : M_START;
						end else if (rdata_q.link == NONE) begin
							res_st_q <= ST_BADADDR;
							state_q  <= DONE;
						end else begin
							cur_q <= rdata_q.link[IB-1:0];
						end
					end
					M_START: begin
						cur_q   <= head_q[IB-1:0];
						state_q <= M_CUR;
					end
					M_CUR: begin
						ent_q   <= rdata_q;
						nxt_q   <= rdata_q.link[IB-1:0];
						state_q <= (rdata_q.link == NONE) ? DONE : M_NXT;
					end
					M_NXT: begin
						if (mergeable) begin
							ent_q          <= merged;
							spare_q[nxt_q] <= 1'b1;
						end else begin
							ent_q <= rdata_q;
							cur_q <= nxt_q;
						end
						nxt_q <= rdata_q.link[IB-1:0];
						if (rdata_q.link == NONE) state_q <= DONE;
					end
					DONE: begin
						if (!out_v_q || m_tready) begin
							out_v_q    <= 1'b1;
							out_addr_q <= res_addr_q;
							out_st_q   <= res_st_q;
							state_q    <= IDLE;
						end
					end
					default: state_q <= IDLE;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[21:20] != ST_OK) |-> (m_tdata[19:0] == '0))
		else $error("failed request returned nonzero address");
	a_head_not_spare: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE) && (head_q != NONE) |-> !spare_q[head_q[IB-1:0]])
		else $error("list head marked spare");
	a_split_claims: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == A_CHK) && fit && split |=> !spare_q[ent_q.link[IB-1:0]])
		else $error("split entry still spare");
`endif
endmodule

[tb/first_fit_segment_allocator_top_tb.sv]
// Testbench for first_fit_segment_allocator_top: directed table, then random
// allocate/free traffic checked against an in-bench segment-list predictor.
// Depends on ffsa_pkg and the top-level RTL.
module first_fit_segment_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffsa_pkg::*;

	localparam int NSEG = MAX_SEGMENTS_DEF;
	localparam int HDR  = HEADER_BYTES_DEF;
	localparam int ALN  = ALIGN_BYTES_DEF;
	localparam int NONE = NSEG;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [39:0]       s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic              cfg_we = 1'b0;
	logic [HEAP_W-1:0] cfg_wdata = '0;

	first_fit_segment_allocator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	typedef struct packed {
		logic [19:0] address;
		status_t     status;
	} grant_t;

	typedef struct {
		logic        mode;
		logic [19:0] size;
		logic [19:0] faddr;
		logic        typed;
		grant_t      want;
	} row_t;

	// predictor state
	logic [20:0] seg_start [NSEG];
	logic [21:0] seg_len [NSEG];
	logic        seg_free [NSEG];
	int          seg_next [NSEG];
	int          head;
	logic        spare [NSEG];
	logic [20:0] heap_sz;

	grant_t grants_due [$];
	logic [19:0] live_addrs [$];
	int errors = 0;
	int stall_hold = 0;
	bit quiet = 1'b0;

	task automatic report(input string what, input grant_t got, input grant_t exp);
		errors++;
		$display("mismatch %s: got addr %h st %0d, want addr %h st %0d",
			what, got.address, got.status, exp.address, exp.status);
	endtask

	function automatic void rebuild(input logic [20:0] v);
		heap_sz = (v > 21'h100000) ? 21'h100000 : v;
		for (int i = 0; i < NSEG; i++) spare[i] = 1'b1;
		head = NONE;
		if (heap_sz >= HDR + ALN) begin
			seg_start[0] = '0;
			seg_len[0] = 22'(heap_sz) - HDR;
			seg_free[0] = 1'b1;
			seg_next[0] = NONE;
			spare[0] = 1'b0;
			head = 0;
		end
	endfunction

	function automatic void coalesce();
		int cur, nx, steps;
		cur = head;
		steps = 0;
		while (cur < NONE && steps < NSEG) begin
			nx = seg_next[cur];
			if (nx >= NONE) break;
			if (seg_free[cur] && seg_free[nx] &&
					22'(seg_start[cur]) + HDR + seg_len[cur] == 22'(seg_start[nx])) begin
				seg_len[cur] = seg_len[cur] + HDR + seg_len[nx];
				seg_next[cur] = seg_next[nx];
				spare[nx] = 1'b1;
			end else begin
				cur = nx;
			end
			steps++;
		end
	endfunction

	function automatic grant_t allocate(input logic [19:0] size);
		grant_t g;
		logic [21:0] need;
		int cur, steps, sp;
		g.address = '0;
		g.status = ST_NOFIT;
		if (size == 0) return g;
		need = ((22'(size) + ALN - 1) / ALN) * ALN;
		cur = head;
		steps = 0;
		while (cur < NONE && steps < NSEG) begin
			if (seg_free[cur] && seg_len[cur] >= need) break;
			cur = seg_next[cur];
			steps++;
		end
		if (cur >= NONE || steps >= NSEG) return g;
		if (seg_len[cur] >= need + HDR + ALN) begin
			sp = NONE;
			for (int i = NSEG - 1; i >= 0; i--) if (spare[i]) sp = i;
			if (sp < NONE) begin
				seg_start[sp] = 21'(22'(seg_start[cur]) + HDR + need);
				seg_len[sp] = seg_len[cur] - need - HDR;
				seg_free[sp] = 1'b1;
				seg_next[sp] = seg_next[cur];
				spare[sp] = 1'b0;
				seg_len[cur] = need;
				seg_next[cur] = sp;
			end
		end
		seg_free[cur] = 1'b0;
		g.address = 20'(seg_start[cur] + HDR);
		g.status = ST_OK;
		return g;
	endfunction

	function automatic grant_t release_at(input logic [19:0] a);
		grant_t g;
		int cur, steps;
		g.address = '0;
		g.status = ST_BADADDR;
		cur = head;
		steps = 0;
		while (cur < NONE && steps < NSEG) begin
			if (22'(seg_start[cur]) + HDR == 22'(a)) begin
				if (seg_free[cur]) return g;
				seg_free[cur] = 1'b1;
				coalesce();
				g.status = ST_OK;
				return g;
			end
			cur = seg_next[cur];
			steps++;
		end
		return g;
	endfunction

	// tvalid stays high into the next send; callers drop it when traffic pauses
	task automatic send(input logic mode, input logic [19:0] size, input logic [19:0] fa,
			input bit typed, input grant_t want);
		grant_t p;
		if (!quiet && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (!quiet && $urandom_range(99) < 9);
		end
		p = mode ? release_at(fa) : allocate(size);
		if (typed && p != want) report("table", p, want);
		if (!mode && p.status == ST_OK) live_addrs.push_back(p.address);
		grants_due.push_back(p);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {fa, size};
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		grant_t got, exp;
		if (m_tvalid && m_tready) begin
			got.address = m_tdata[19:0];
			got.status = status_t'(m_tdata[21:20]);
			if (grants_due.size() == 0) begin
				report("unexpected result", got, '0);
			end else begin
				exp = grants_due.pop_front();
				if (got.address !== exp.address || got.status !== exp.status)
					report("result", got, exp);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 9);
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (2 * NSEG + 20) @(posedge clk);
	endtask

	task automatic set_heap(input logic [20:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		rebuild(v);
		live_addrs.delete();
		repeat (3) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int k, r;
		logic [19:0] sz, fa;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				sz = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(400));
				send(1'b0, sz, 20'($urandom), 1'b0, '0);
			end else if (r < 85 && live_addrs.size() != 0) begin
				k = $urandom_range(live_addrs.size() - 1);
				fa = live_addrs[k];
				live_addrs.delete(k);
				send(1'b1, 20'($urandom), fa, 1'b0, '0);
			end else begin
				send(1'b1, 20'($urandom), 20'($urandom), 1'b0, '0);
			end
		end
	endtask

	row_t table_rows [] = '{
		'{1'b0, 20'd0,       20'd0,       1'b1, '{20'd0,  ST_NOFIT}},
		'{1'b0, 20'd1,       20'hFFFFF,   1'b1, '{20'd16, ST_OK}},
		'{1'b0, 20'hFFFFF,   20'd0,       1'b1, '{20'd0,  ST_NOFIT}},
		'{1'b1, 20'hFFFFF,   20'hFFFFF,   1'b1, '{20'd0,  ST_BADADDR}},
		'{1'b1, 20'd0,       20'd16,      1'b1, '{20'd0,  ST_OK}},
		'{1'b1, 20'd0,       20'd16,      1'b1, '{20'd0,  ST_BADADDR}},
		'{1'b0, 20'd16,      20'd0,       1'b0, '0},
		'{1'b0, 20'd17,      20'd0,       1'b0, '0},
		'{1'b0, 20'd100,     20'd0,       1'b0, '0},
		'{1'b1, 20'd0,       20'd40,      1'b1, '{20'd0,  ST_BADADDR}},
		'{1'b1, 20'd0,       20'd48,      1'b0, '0},
		'{1'b1, 20'd0,       20'd16,      1'b0, '0},
		'{1'b0, 20'd65520,   20'd0,       1'b0, '0},
		'{1'b1, 20'd0,       20'd0,       1'b1, '{20'd0,  ST_BADADDR}}
	};

	initial begin
		rebuild(HEAP_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		foreach (table_rows[i])
			send(table_rows[i].mode, table_rows[i].size, table_rows[i].faddr,
				table_rows[i].typed, table_rows[i].want);
		set_heap(21'h1FFFFF);
		send(1'b0, 20'hFFFF0, 20'd0, 1'b1, '{20'd16, ST_OK});
		set_heap(21'd31);
		send(1'b0, 20'd1, 20'd0, 1'b1, '{20'd0, ST_NOFIT});
		set_heap(21'd32);
		send(1'b0, 20'd16, 20'd0, 1'b1, '{20'd16, ST_OK});
		set_heap(21'd0);
		send(1'b0, 20'd1, 20'd0, 1'b1, '{20'd0, ST_NOFIT});
		// small heap: fills up fast, no-fit paths
		set_heap(21'd2048);
		random_phase(150);
		// lots of heap: exhausts spare entries
		set_heap(21'h100000);
		quiet = 1'b1;
		random_phase(150);
		quiet = 1'b0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		stall_hold = 400;
		random_phase(150);
		set_heap(HEAP_RESET);
		random_phase(300);
		drain();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
